// ===== design/adts_pkg.sv =====
// Shared types and constants for the ADTS frame scanner.
package adts_pkg;

  localparam int OFFSET_BITS_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int OUT_OFFSET_W    = 32;

  localparam logic [7:0]  SYNC_BYTE     = 8'hFF;
  localparam logic [3:0]  SYNC_NIBBLE   = 4'hF;
  localparam logic [1:0]  LAYER_ZERO    = 2'b00;
  localparam logic [1:0]  HDR_LAST_IDX  = 2'd3;
  localparam logic [12:0] MIN_FRAME_LEN = 13'd7;
  localparam logic [12:0] HEADER_LEN    = 13'd6;

  typedef enum logic [2:0] {
    MODE_SEARCH = 3'b001,
    MODE_GATHER = 3'b010,
    MODE_SKIP   = 3'b100
  } scan_mode_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] header_offset;
    logic        mpeg_id;
    logic        no_crc;
    logic [1:0]  profile;
    logic [3:0]  rate_index;
    logic        private_flag;
    logic [2:0]  channel_config;
    logic        original_flag;
    logic        home_flag;
    logic [1:0]  copyright_bits;
    logic [12:0] frame_length;
    logic        short_frame;
  } out_item_t;

  // Raw header event: offset of the sync, header bytes 1..4, and byte 5.
  typedef struct packed {
    logic [OUT_OFFSET_W-1:0] offset;
    logic [31:0]             hdr;
    logic [7:0]              last_hdr_byte;
  } hdr_evt_t;

endpackage

// ===== design/adts_frame_scanner.sv =====
// Top level of the ADTS frame scanner: scanner front end, event queue, output stage.
//
// The scanner takes one audio byte per cycle while in_stall_o is low and reports each ADTS
// header it finds: a 0xFF byte followed by a byte with high nibble 0xF and zero layer bits
// starts a header, bytes 2 to 5 are gathered, and with byte 5 one item leaves carrying the
// stream offset of the 0xFF byte and the decoded fields. The frame body (frame_length minus
// 6 bytes) is then skipped and search resumes; a frame_length below 7 is flagged through
// short_frame and search resumes right after byte 5. A byte marked last_byte is fully
// processed, any header it completes is still reported, and the scanner then returns to its
// reset state with the offset counter back at zero. The offset counter is OFFSET_BITS wide
// and wraps; header_offset carries its low 32 bits. Throughput is one byte per cycle while
// in_stall_o is low: the byte path is a compare, capture or decrement in the front end.
// Headers pass through a QUEUE_DEPTH-entry queue into the output register: each result is
// written into the queue with its fifth header byte, then loaded into the output register
// and presented there until accepted. in_stall_o rises only while that queue is full;
// for QUEUE_DEPTH above one, that takes an output stall that lets results pile up.
module adts_frame_scanner
  import adts_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic     push;
  logic     queue_full;
  hdr_evt_t front_evt;
  logic     pop;
  logic     head_valid;
  hdr_evt_t head_evt;

  // Scanner: classify each byte and raise a header event with the fifth header byte.
  adts_scan_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .evt_o        (front_evt)
  );

  // Decouple the scanner from output back-pressure.
  adts_evt_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_evt),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  (head_evt)
  );

  // Decode header bytes into fields and drive the result channel.
  adts_out_stage u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_evt),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

// ===== design/adts_scan_front.sv =====
// Front end: byte scanner that finds ADTS syncs, gathers headers and skips frame bodies.
module adts_scan_front
  import adts_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  input  logic     queue_full_i,
  output logic     push_o,
  output hdr_evt_t evt_o
);

  localparam int CopyBits = (OFFSET_BITS < OUT_OFFSET_W) ? OFFSET_BITS : OUT_OFFSET_W;

  scan_mode_e             mode_q, mode_d;
  logic                   prev_ff_q, prev_ff_d;
  logic [1:0]             hidx_q, hidx_d;
  logic [31:0]            hdr_q, hdr_d;
  logic [12:0]            skip_q, skip_d;
  logic [OFFSET_BITS-1:0] cnt_q, cnt_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;

  logic        accept;
  logic [7:0]  b;
  logic [12:0] frame_len;
  logic [12:0] skip_dec;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign b          = in_item_i.data_byte;
  assign frame_len  = {hdr_q[9:8], hdr_q[7:0], b[7:5]};
  assign skip_dec   = (skip_q != 13'd0) ? (skip_q - 13'd1) : skip_q;

  assign evt_o.offset        = OUT_OFFSET_W'(start_q[CopyBits-1:0]);
  assign evt_o.hdr           = hdr_q;
  assign evt_o.last_hdr_byte = b;

  always_comb begin
    mode_d    = mode_q;
    prev_ff_d = prev_ff_q;
    hidx_d    = hidx_q;
    hdr_d     = hdr_q;
    skip_d    = skip_q;
    cnt_d     = cnt_q;
    start_d   = start_q;
    push_o    = 1'b0;
    if (accept) begin
      case (mode_q)
        MODE_GATHER: begin
          if (hidx_q == HDR_LAST_IDX) begin
            push_o    = 1'b1;
            prev_ff_d = 1'b0;
            hidx_d    = 2'd0;
            if (frame_len < MIN_FRAME_LEN) begin
              mode_d = MODE_SEARCH;
              skip_d = 13'd0;
            end else begin
              mode_d = MODE_SKIP;
              skip_d = frame_len - HEADER_LEN;
            end
          end else begin
            hdr_d  = {hdr_q[23:0], b};
            hidx_d = hidx_q + 2'd1;
          end
        end
        MODE_SKIP: begin
          skip_d = skip_dec;
          if (skip_dec == 13'd0) begin
            mode_d    = MODE_SEARCH;
            prev_ff_d = 1'b0;
          end
        end
        default: begin
          mode_d = MODE_SEARCH;
          if (prev_ff_q && (b[7:4] == SYNC_NIBBLE) && (b[2:1] == LAYER_ZERO)) begin
            mode_d    = MODE_GATHER;
            start_d   = cnt_q - OFFSET_BITS'(1);
            hdr_d     = {24'd0, b};
            hidx_d    = 2'd0;
            prev_ff_d = 1'b0;
          end else begin
            prev_ff_d = (b == SYNC_BYTE);
          end
        end
      endcase
      cnt_d = cnt_q + OFFSET_BITS'(1);
      if (in_item_i.last_byte) begin
        mode_d    = MODE_SEARCH;
        prev_ff_d = 1'b0;
        hidx_d    = 2'd0;
        skip_d    = 13'd0;
        cnt_d     = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_SEARCH;
      prev_ff_q <= 1'b0;
      hidx_q    <= 2'd0;
      skip_q    <= 13'd0;
      cnt_q     <= '0;
    end else begin
      mode_q    <= mode_d;
      prev_ff_q <= prev_ff_d;
      hidx_q    <= hidx_d;
      skip_q    <= skip_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q   <= hdr_d;
    start_q <= start_d;
  end

`ifndef ASSERT_OFF
  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_SKIP) |-> (skip_q != 13'd0))
    else $error("skip mode with nothing left to skip");
  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_item_i.last_byte) |=> ((mode_q == MODE_SEARCH) && (cnt_q == '0)))
    else $error("scanner not back to reset after final byte");
  a_push_on_header_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> ((mode_q == MODE_SKIP) || (mode_q == MODE_SEARCH)))
    else $error("scanner stayed in gather after emitting a header");
`endif

endmodule

// ===== design/adts_evt_queue.sv =====
// Short queue of header events between the scanner and the output stage.
module adts_evt_queue
  import adts_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  hdr_evt_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output hdr_evt_t data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  hdr_evt_t            slots_q [DEPTH];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [CntW-1:0]     cnt_q;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slots_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("header event pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("header event popped from an empty queue");
`endif

endmodule

// ===== design/adts_out_stage.sv =====
// Back end: decode header events into result fields and hold them in the output register.
module adts_out_stage
  import adts_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  hdr_evt_t  head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      out_valid_q;
  out_item_t out_q, out_d;
  logic [7:0] b1, b2, b3, b4, b5;
  logic [12:0] len;

  assign b1  = head_i.hdr[31:24];
  assign b2  = head_i.hdr[23:16];
  assign b3  = head_i.hdr[15:8];
  assign b4  = head_i.hdr[7:0];
  assign b5  = head_i.last_hdr_byte;
  assign len = {b3[1:0], b4, b5[7:5]};

  always_comb begin
    out_d.header_offset     = head_i.offset;
    out_d.mpeg_id           = b1[3];
    out_d.no_crc            = b1[0];
    out_d.profile           = b2[7:6];
    out_d.rate_index        = b2[5:2];
    out_d.private_flag      = b2[1];
    out_d.channel_config    = {b2[0], b3[7:6]};
    out_d.original_flag     = b3[5];
    out_d.home_flag         = b3[4];
    out_d.copyright_bits    = b3[3:2];
    out_d.frame_length      = len;
    out_d.short_frame       = (len < MIN_FRAME_LEN);
  end

  // Load a new item whenever the register is empty or being drained.
  assign pop_o       = head_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= head_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

`ifndef ASSERT_OFF
  a_short_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.short_frame == (out_q.frame_length < MIN_FRAME_LEN)))
    else $error("short_frame flag disagrees with frame_length");
`endif

endmodule
